/* sv/hmtn_pkg.sv */
// Shared types, constants and the divide step for the heightmap thumbnail generator.
// No dependencies; used by every other file of the block.
package hmtn_pkg;

    localparam int THUMB_SIZE = 256;
    localparam int MAX_DIM    = 256;
    localparam int DIM_W      = 9;
    localparam int POS_W      = 8;
    localparam int SAMPLE_W   = 16;
    localparam int ADDR_W     = 16;
    localparam int GRAY_W     = 8;
    localparam int NUM_W      = 24;
    localparam int DEN_W      = 16;
    localparam int QUO_W      = 8;
    localparam int MARK_W     = 5;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [DIM_W-1:0]  THUMB_EXT  = DIM_W'(THUMB_SIZE);
    localparam logic [DIM_W-1:0]  DIM_LIMIT  = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0]  DIM_MIN    = DIM_W'(2);
    localparam logic [MARK_W-1:0] MARK_LEN   = MARK_W'(16);
    localparam logic [GRAY_W-1:0] GRAY_BG    = GRAY_W'(24);
    localparam logic [GRAY_W-1:0] GRAY_FLAT  = GRAY_W'(127);
    localparam logic [GRAY_W-1:0] GRAY_WHITE = GRAY_W'(255);
    localparam logic [GRAY_W-1:0] GRAY_BLACK = GRAY_W'(0);

    typedef enum logic [1:0] {
        REG_WIDTH   = 2'd0,
        REG_HEIGHT  = 2'd1,
        REG_FLOOR   = 2'd2,
        REG_CEILING = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        PX_ERR    = 3'd0,
        PX_BG     = 3'd1,
        PX_WHITE  = 3'd2,
        PX_SAMPLE = 3'd3,
        PX_FLAT   = 3'd4,
        PX_LOW    = 3'd5,
        PX_HIGH   = 3'd6
    } px_cls_t;

    typedef struct packed {
        logic    valid;
        logic    req;
        px_cls_t cls;
    } ctl_t;

    typedef enum logic [2:0] {
        SU_IDLE = 3'b001,
        SU_LOAD = 3'b010,
        SU_DIV  = 3'b100
    } setup_state_t;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                                input logic nb,
                                                input logic [DEN_W-1:0] den);
        logic [DEN_W:0] sh;
        logic [DEN_W:0] diff;
        sh   = {rem, nb};
        diff = sh - {1'b0, den};
        if (sh >= {1'b0, den})
        begin
            return {1'b1, diff[DEN_W-1:0]};
        end
        return {1'b0, sh[DEN_W-1:0]};
    endfunction

endpackage

/* sv/hmtn_div8.sv */
// Pipelined restoring divider, one quotient bit per stage, quotient known below 256.
// Depends on hmtn_pkg for widths and the divide step.
module hmtn_div8
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [hmtn_pkg::NUM_W-1:0]  num,
    input  logic [hmtn_pkg::DEN_W-1:0]  den,
    output logic [hmtn_pkg::QUO_W-1:0]  quo
);

    localparam int QW = hmtn_pkg::QUO_W;
    localparam int DW = hmtn_pkg::DEN_W;

    logic [DW-1:0] rem_reg [0:QW-1];
    logic [QW-1:0] low_reg [0:QW-1];
    logic [QW-1:0] q_reg   [0:QW-1];
    logic [DW:0]   step    [0:QW-1];

    always_comb
    begin
        step[0] = hmtn_pkg::div_step(num[hmtn_pkg::NUM_W-1:QW], num[QW-1], den);
        for (int k = 1; k < QW; k++)
        begin
            step[k] = hmtn_pkg::div_step(rem_reg[k-1], low_reg[k-1][QW-1], den);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= step[0][DW-1:0];
            q_reg[0]   <= {{(QW-1){1'b0}}, step[0][DW]};
            low_reg[0] <= {num[QW-2:0], 1'b0};
            for (int k = 1; k < QW; k++)
            begin
                rem_reg[k] <= step[k][DW-1:0];
                q_reg[k]   <= {q_reg[k-1][QW-2:0], step[k][DW]};
                low_reg[k] <= {low_reg[k-1][QW-2:0], 1'b0};
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule

/* sv/heightmap_thumbnail_pixel_gen.sv */
// Heightmap thumbnail pixel generator: top level with sample memory and pixel pipeline.
// Depends on hmtn_pkg and hmtn_div8.
//
// Takes one word per cycle while in_stall is low, sample writes and pixel requests alike,
// and presents one result word per pixel request, in order. Writes and reads share the
// single port of the 64K x 16 sample memory at one pipeline stage, so every request sees
// exactly the writes accepted before it. After a write of source_width or source_height,
// input stalls while a bit-serial divider recomputes the draw size. A result word that
// meets an output stall goes into a skid word, and the pipeline freezes in the cycle after.
module heightmap_thumbnail_pixel_gen
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hmtn_pkg::PADDR_W-1:0]        paddr,
    input  logic [hmtn_pkg::PDATA_W-1:0]        pwdata,
    output logic [hmtn_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [hmtn_pkg::ADDR_W-1:0]         sample_index,
    input  logic [hmtn_pkg::SAMPLE_W-1:0]       sample_value,
    input  logic [hmtn_pkg::POS_W-1:0]          pixel_col,
    input  logic [hmtn_pkg::POS_W-1:0]          pixel_row,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [hmtn_pkg::GRAY_W-1:0]         gray_level,
    output logic                                config_error
);

    localparam int DIMW = hmtn_pkg::DIM_W;
    localparam int PW   = hmtn_pkg::POS_W;
    localparam int SW   = hmtn_pkg::SAMPLE_W;
    localparam int AW   = hmtn_pkg::ADDR_W;
    localparam int GW   = hmtn_pkg::GRAY_W;
    localparam int QW   = hmtn_pkg::QUO_W;
    localparam int NW   = hmtn_pkg::NUM_W;
    localparam int DNW  = hmtn_pkg::DEN_W;
    localparam int LAST = 21;

    typedef struct packed {
        logic [AW-1:0] idx;
        logic [SW-1:0] val;
    } pay_t;

    // configuration
    logic [DIMW-1:0] width_reg;
    logic [DIMW-1:0] height_reg;
    logic [SW-1:0]   floor_reg;
    logic [SW-1:0]   ceil_reg;
    logic            cfg_wr;
    logic            dim_wr;
    hmtn_pkg::reg_idx_t cfg_sel;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = hmtn_pkg::reg_idx_t'(paddr[3:2]);
    assign dim_wr  = cfg_wr && (cfg_sel == hmtn_pkg::REG_WIDTH ||
                                cfg_sel == hmtn_pkg::REG_HEIGHT);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            floor_reg  <= '0;
            ceil_reg   <= '1;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                hmtn_pkg::REG_WIDTH:   width_reg  <= pwdata[DIMW-1:0];
                hmtn_pkg::REG_HEIGHT:  height_reg <= pwdata[DIMW-1:0];
                hmtn_pkg::REG_FLOOR:   floor_reg  <= pwdata[SW-1:0];
                hmtn_pkg::REG_CEILING: ceil_reg   <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            hmtn_pkg::REG_WIDTH:   prdata = 32'(width_reg);
            hmtn_pkg::REG_HEIGHT:  prdata = 32'(height_reg);
            hmtn_pkg::REG_FLOOR:   prdata = 32'(floor_reg);
            hmtn_pkg::REG_CEILING: prdata = 32'(ceil_reg);
            default:               prdata = '0;
        endcase
    end

    // draw size setup
    logic [DIMW-1:0] wc;
    logic [DIMW-1:0] hc;
    hmtn_pkg::setup_state_t state_reg, state_next;
    logic [DIMW-1:0] mx_reg;
    logic [DIMW-1:0] mn_reg;
    logic [DIMW-1:0] srem_reg;
    logic [QW-1:0]   sq_reg;
    logic [2:0]      cnt_reg;
    logic            wide_reg;
    logic [DIMW-1:0] dw_reg;
    logic [DIMW-1:0] dh_reg;
    logic [DIMW:0]   srem2;
    logic            sbit;
    logic [DIMW:0]   sdiff;
    logic [QW-1:0]   sq_next;
    logic [DIMW-1:0] small_ext;
    logic            busy;

    assign wc        = (width_reg > hmtn_pkg::DIM_LIMIT) ? hmtn_pkg::DIM_LIMIT : width_reg;
    assign hc        = (height_reg > hmtn_pkg::DIM_LIMIT) ? hmtn_pkg::DIM_LIMIT : height_reg;
    assign srem2     = {srem_reg, 1'b0};
    assign sbit      = srem2 >= {1'b0, mx_reg};
    assign sdiff     = srem2 - {1'b0, mx_reg};
    assign sq_next   = {sq_reg[QW-2:0], sbit};
    assign small_ext = (mn_reg == mx_reg) ? hmtn_pkg::THUMB_EXT : {1'b0, sq_next};
    assign busy      = state_reg != hmtn_pkg::SU_IDLE;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hmtn_pkg::SU_IDLE: ;
            hmtn_pkg::SU_LOAD: state_next = hmtn_pkg::SU_DIV;
            hmtn_pkg::SU_DIV:
            begin
                if (cnt_reg == 3'(QW - 1))
                begin
                    state_next = hmtn_pkg::SU_IDLE;
                end
            end
            default: state_next = hmtn_pkg::SU_IDLE;
        endcase
        // restart on every dimension write
        if (dim_wr)
        begin
            state_next = hmtn_pkg::SU_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hmtn_pkg::SU_IDLE;
            dw_reg    <= hmtn_pkg::THUMB_EXT;
            dh_reg    <= hmtn_pkg::THUMB_EXT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == hmtn_pkg::SU_LOAD)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == hmtn_pkg::SU_DIV)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'(QW - 1))
                begin
                    dw_reg <= wide_reg ? hmtn_pkg::THUMB_EXT : small_ext;
                    dh_reg <= wide_reg ? small_ext : hmtn_pkg::THUMB_EXT;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == hmtn_pkg::SU_LOAD)
        begin
            wide_reg <= wc >= hc;
            mx_reg   <= (wc >= hc) ? wc : hc;
            mn_reg   <= (wc >= hc) ? hc : wc;
            srem_reg <= (wc >= hc) ? hc : wc;
            sq_reg   <= '0;
        end
        else if (state_reg == hmtn_pkg::SU_DIV)
        begin
            srem_reg <= sbit ? sdiff[DIMW-1:0] : srem2[DIMW-1:0];
            sq_reg   <= sq_next;
        end
    end

    // derived geometry
    logic [DIMW-1:0]             xpad;
    logic [DIMW-1:0]             ypad;
    logic [PW-1:0]               ox;
    logic [PW-1:0]               oy;
    logic [DIMW-1:0]             dmin;
    logic [hmtn_pkg::MARK_W-1:0] mark;

    assign xpad = hmtn_pkg::THUMB_EXT - dw_reg;
    assign ypad = hmtn_pkg::THUMB_EXT - dh_reg;
    assign ox   = xpad[DIMW-1:1];
    assign oy   = ypad[DIMW-1:1];
    assign dmin = (dw_reg < dh_reg) ? dw_reg : dh_reg;
    assign mark = (dmin > DIMW'(hmtn_pkg::MARK_LEN)) ? hmtn_pkg::MARK_LEN
                                                     : dmin[hmtn_pkg::MARK_W-1:0];

    // pipeline control
    logic            en;
    logic            accept;
    logic            skid_v_reg;
    logic [GW-1:0]   skid_gray_reg;
    logic            skid_err_reg;
    logic            out_v_reg;
    logic [GW-1:0]   out_gray_reg;
    logic            out_err_reg;

    assign en       = !skid_v_reg;
    assign in_stall = busy || skid_v_reg;
    assign accept   = in_valid && !in_stall;

    logic            v0_reg;
    logic            req0_reg;
    logic [PW-1:0]   col0_reg;
    logic [PW-1:0]   row0_reg;
    pay_t            pay0_reg;
    hmtn_pkg::ctl_t  ctl_reg [1:LAST];
    pay_t            pay_reg [1:10];
    logic [PW-1:0]   x1_reg;
    logic [PW-1:0]   y1_reg;
    logic [AW-1:0]   nx2_reg;
    logic [AW-1:0]   ny2_reg;
    logic [AW-1:0]   addr11_reg;
    logic [SW-1:0]   wval11_reg;
    logic [SW-1:0]   rdata_reg;
    logic [NW-1:0]   num13_reg;

    // stage 0 to 1: classify the position
    logic [DIMW-1:0] col9;
    logic [DIMW-1:0] row9;
    logic            in_area;
    logic [PW-1:0]   x0;
    logic [PW-1:0]   y0;
    logic            white;
    logic            cfg_bad;
    hmtn_pkg::px_cls_t cls0;

    assign col9    = {1'b0, col0_reg};
    assign row9    = {1'b0, row0_reg};
    assign in_area = col9 >= {1'b0, ox} && col9 < ({1'b0, ox} + dw_reg) &&
                     row9 >= {1'b0, oy} && row9 < ({1'b0, oy} + dh_reg);
    assign x0      = col0_reg - ox;
    assign y0      = row0_reg - oy;
    assign white   = (y0 == '0 && x0 < PW'(mark)) || (x0 == '0 && y0 < PW'(mark));
    assign cfg_bad = width_reg < hmtn_pkg::DIM_MIN || height_reg < hmtn_pkg::DIM_MIN;

    always_comb
    begin
        if (cfg_bad)
        begin
            cls0 = hmtn_pkg::PX_ERR;
        end
        else if (!in_area)
        begin
            cls0 = hmtn_pkg::PX_BG;
        end
        else if (white)
        begin
            cls0 = hmtn_pkg::PX_WHITE;
        end
        else
        begin
            cls0 = hmtn_pkg::PX_SAMPLE;
        end
    end

    // stage 11 address, stage 13 gray numerator
    logic [QW-1:0]   sx;
    logic [QW-1:0]   sy;
    logic [AW-1:0]   raster;
    logic [SW-1:0]   above;
    logic [NW-1:0]   num13;
    logic            flat;
    hmtn_pkg::px_cls_t cls13;
    logic [DNW-1:0]  range;
    logic [QW-1:0]   gquo;

    assign raster = AW'(sy * wc) + AW'(sx);
    assign above  = rdata_reg - floor_reg;
    assign num13  = {above, 8'b0} - NW'(above);
    assign flat   = ceil_reg <= floor_reg;
    assign range  = ceil_reg - floor_reg;

    always_comb
    begin
        cls13 = ctl_reg[12].cls;
        if (ctl_reg[12].cls == hmtn_pkg::PX_SAMPLE)
        begin
            if (flat)
            begin
                cls13 = hmtn_pkg::PX_FLAT;
            end
            else if (rdata_reg <= floor_reg)
            begin
                cls13 = hmtn_pkg::PX_LOW;
            end
            else if (rdata_reg >= ceil_reg)
            begin
                cls13 = hmtn_pkg::PX_HIGH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            for (int k = 1; k <= LAST; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            v0_reg <= accept;
            ctl_reg[1].valid <= v0_reg;
            ctl_reg[1].req   <= req0_reg;
            ctl_reg[1].cls   <= cls0;
            for (int k = 2; k <= LAST; k++)
            begin
                ctl_reg[k].valid <= ctl_reg[k-1].valid;
                ctl_reg[k].req   <= ctl_reg[k-1].req;
                ctl_reg[k].cls   <= (k == 13) ? cls13 : ctl_reg[k-1].cls;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (accept)
            begin
                req0_reg     <= command;
                col0_reg     <= pixel_col;
                row0_reg     <= pixel_row;
                pay0_reg.idx <= sample_index;
                pay0_reg.val <= sample_value;
            end
            x1_reg         <= x0;
            y1_reg         <= y0;
            pay_reg[1]     <= pay0_reg;
            for (int k = 2; k <= 10; k++)
            begin
                pay_reg[k] <= pay_reg[k-1];
            end
            nx2_reg    <= AW'(x1_reg * PW'(wc - DIMW'(1)));
            ny2_reg    <= AW'(y1_reg * PW'(hc - DIMW'(1)));
            addr11_reg <= ctl_reg[10].req ? raster : pay_reg[10].idx;
            wval11_reg <= pay_reg[10].val;
            num13_reg  <= num13;
        end
    end

    // sample memory: one port, writes and reads in order
    logic [SW-1:0] mem [0:(1 << AW) - 1];

    always_ff @(posedge clk)
    begin
        if (en && ctl_reg[11].valid)
        begin
            if (!ctl_reg[11].req)
            begin
                mem[addr11_reg] <= wval11_reg;
            end
            else
            begin
                rdata_reg <= mem[addr11_reg];
            end
        end
    end

    hmtn_div8 u_div_x
    (
        .clk (clk),
        .en  (en),
        .num (NW'(nx2_reg)),
        .den (DNW'(PW'(dw_reg - DIMW'(1)))),
        .quo (sx)
    );

    hmtn_div8 u_div_y
    (
        .clk (clk),
        .en  (en),
        .num (NW'(ny2_reg)),
        .den (DNW'(PW'(dh_reg - DIMW'(1)))),
        .quo (sy)
    );

    hmtn_div8 u_div_gray
    (
        .clk (clk),
        .en  (en),
        .num (num13_reg),
        .den (range),
        .quo (gquo)
    );

    // result select and output with skid word
    logic [GW-1:0] res_gray;
    logic          res_err;
    logic          res_v;
    logic          out_free;

    always_comb
    begin
        res_err = 1'b0;
        case (ctl_reg[LAST].cls) inside
            hmtn_pkg::PX_ERR:
            begin
                res_gray = hmtn_pkg::GRAY_BLACK;
                res_err  = 1'b1;
            end
            hmtn_pkg::PX_BG:                    res_gray = hmtn_pkg::GRAY_BG;
            hmtn_pkg::PX_WHITE, hmtn_pkg::PX_HIGH: res_gray = hmtn_pkg::GRAY_WHITE;
            hmtn_pkg::PX_FLAT:                  res_gray = hmtn_pkg::GRAY_FLAT;
            hmtn_pkg::PX_LOW:                   res_gray = hmtn_pkg::GRAY_BLACK;
            hmtn_pkg::PX_SAMPLE:                res_gray = gquo;
            default:                            res_gray = hmtn_pkg::GRAY_BLACK;
        endcase
    end

    assign res_v    = en && ctl_reg[LAST].valid && ctl_reg[LAST].req;
    assign out_free = !out_v_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (out_free)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
        end
        else if (res_v)
        begin
            if (out_free)
            begin
                out_v_reg <= 1'b1;
            end
            else
            begin
                skid_v_reg <= 1'b1;
            end
        end
        else if (out_free)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_free)
            begin
                out_gray_reg <= skid_gray_reg;
                out_err_reg  <= skid_err_reg;
            end
        end
        else if (res_v)
        begin
            if (out_free)
            begin
                out_gray_reg <= res_gray;
                out_err_reg  <= res_err;
            end
            else
            begin
                skid_gray_reg <= res_gray;
                skid_err_reg  <= res_err;
            end
        end
    end

    assign out_valid    = out_v_reg;
    assign gray_level   = out_gray_reg;
    assign config_error = out_err_reg;

endmodule

/* sv/hmtn_checker.sv */
// Port-level checks for the heightmap thumbnail generator, bound to the top level.
// Depends on hmtn_pkg and heightmap_thumbnail_pixel_gen.
module hmtn_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic                          pready,
    input logic [hmtn_pkg::PADDR_W-1:0]  paddr,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [hmtn_pkg::GRAY_W-1:0]   gray_level,
    input logic                          config_error
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(gray_level) && $stable(config_error))
        else $error("stalled result word changed");

    a_err_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && config_error |-> gray_level == hmtn_pkg::GRAY_BLACK)
        else $error("error word carries nonzero gray");

    a_dim_stall: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready &&
        (paddr[3:2] == hmtn_pkg::REG_WIDTH || paddr[3:2] == hmtn_pkg::REG_HEIGHT)
        |=> in_stall)
        else $error("input not held during draw size update");

endmodule

bind heightmap_thumbnail_pixel_gen hmtn_checker u_hmtn_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .gray_level   (gray_level),
    .config_error (config_error)
);

/* tb/heightmap_thumbnail_pixel_checker.sv */
`timescale 1ns / 100ps
// Checker for the heightmap thumbnail pixel generator: tracks register writes and samples,
// predicts each pixel word and compares it with the block's output. Depends on hmtn_pkg.
module heightmap_thumbnail_pixel_checker
    import hmtn_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                command,
    input  logic [ADDR_W-1:0]   sample_index,
    input  logic [SAMPLE_W-1:0] sample_value,
    input  logic [POS_W-1:0]    pixel_col,
    input  logic [POS_W-1:0]    pixel_row,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [GRAY_W-1:0]   gray_level,
    input  logic                config_error,
    output int                  pending,
    output int                  errors
);

    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic              err;
    } pixel_t;

    logic [SAMPLE_W-1:0] heights [0:65535];
    logic [DIM_W-1:0]    cols_cfg;
    logic [DIM_W-1:0]    rows_cfg;
    logic [15:0]         floor_cfg;
    logic [15:0]         ceil_cfg;
    pixel_t              pixel_q [$];

    function automatic pixel_t shade_pixel(input int col, input int row);
        pixel_t p;
        int w, h, m, dw, dh, ox, oy, x, y, mark, sx, sy, addr, s;
        p.err = 1'b0;
        if (cols_cfg < 2 || rows_cfg < 2)
        begin
            p.err  = 1'b1;
            p.gray = 8'd0;
            return p;
        end
        w  = (cols_cfg > MAX_DIM) ? MAX_DIM : cols_cfg;
        h  = (rows_cfg > MAX_DIM) ? MAX_DIM : rows_cfg;
        m  = (w > h) ? w : h;
        dw = (w * THUMB_SIZE) / m;
        dh = (h * THUMB_SIZE) / m;
        if (dw < 1) dw = 1;
        if (dh < 1) dh = 1;
        ox = (THUMB_SIZE - dw) / 2;
        oy = (THUMB_SIZE - dh) / 2;
        if (col < ox || col >= ox + dw || row < oy || row >= oy + dh)
        begin
            p.gray = 8'd24;
            return p;
        end
        x    = col - ox;
        y    = row - oy;
        mark = (dw < dh) ? dw : dh;
        if (mark > 16) mark = 16;
        if ((y == 0 && x < mark) || (x == 0 && y < mark))
        begin
            p.gray = 8'd255;
            return p;
        end
        sx   = (dw == 1) ? 0 : (x * (w - 1)) / (dw - 1);
        sy   = (dh == 1) ? 0 : (y * (h - 1)) / (dh - 1);
        addr = (sy * w + sx) & 16'hffff;
        s    = heights[addr];
        if (ceil_cfg <= floor_cfg)
            p.gray = 8'd127;
        else if (s <= floor_cfg)
            p.gray = 8'd0;
        else if (s >= ceil_cfg)
            p.gray = 8'd255;
        else
            p.gray = 8'(((s - floor_cfg) * 255) / (ceil_cfg - floor_cfg));
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t e;
        if (!rst_n)
        begin
            cols_cfg  <= '0;
            rows_cfg  <= '0;
            floor_cfg <= '0;
            ceil_cfg  <= 16'hffff;
            pending   <= 0;
            errors    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_WIDTH:   cols_cfg  <= pwdata[DIM_W-1:0];
                    REG_HEIGHT:  rows_cfg  <= pwdata[DIM_W-1:0];
                    REG_FLOOR:   floor_cfg <= pwdata[15:0];
                    REG_CEILING: ceil_cfg  <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (command == 1'b0)
                    heights[sample_index] = sample_value;
                else
                    pixel_q.push_back(shade_pixel(pixel_col, pixel_row));
            end
            if (out_valid && !out_stall)
            begin
                if (pixel_q.size() == 0)
                begin
                    $error("unexpected word: gray_level %0d config_error %0d",
                           gray_level, config_error);
                    errors <= errors + 1;
                end
                else
                begin
                    e = pixel_q.pop_front();
                    if (gray_level !== e.gray || config_error !== e.err)
                    begin
                        if (gray_level !== e.gray)
                            $error("gray_level: expected %0d, actual %0d", e.gray, gray_level);
                        if (config_error !== e.err)
                            $error("config_error: expected %0d, actual %0d",
                                   e.err, config_error);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= pixel_q.size();
        end
    end

endmodule

/* tb/heightmap_thumbnail_pixel_gen_tb.sv */
`timescale 1ns / 100ps
// Testbench top for heightmap_thumbnail_pixel_gen: drives registers, sample writes and pixel
// requests with random gaps and stalls. Depends on hmtn_pkg and heightmap_thumbnail_pixel_checker.
module heightmap_thumbnail_pixel_gen_tb;
    import hmtn_pkg::*;

    localparam int SETTLE = 40;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                command = 1'b0;
    logic [ADDR_W-1:0]   sample_index = '0;
    logic [SAMPLE_W-1:0] sample_value = '0;
    logic [POS_W-1:0]    pixel_col = '0;
    logic [POS_W-1:0]    pixel_row = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [GRAY_W-1:0]   gray_level;
    logic                config_error;
    int                  pending;
    int                  errors;
    int                  gap_pct = 0;
    int                  stall_pct = 0;
    int                  quiet = 0;
    int                  cur_floor, cur_ceil;

    always #5 clk = ~clk;

    heightmap_thumbnail_pixel_gen dut (.*);

    heightmap_thumbnail_pixel_checker checker_i (.*);

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("FAIL heightmap_thumbnail_pixel_gen");
            $finish;
        end
    end

    task automatic write_reg(input reg_idx_t r, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_word(input logic cmd, input int idx, input int val,
                             input int col, input int row);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        sample_index <= ADDR_W'(idx);
        sample_value <= SAMPLE_W'(val);
        pixel_col    <= POS_W'(col);
        pixel_row    <= POS_W'(row);
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic int pick_height();
        case ($urandom_range(7))
            0: return 0;
            1: return 65535;
            2: return cur_floor;
            3: return cur_ceil;
            4: return (cur_floor + 1) & 16'hffff;
            5: return (cur_ceil - 1) & 16'hffff;
            default: return (cur_floor + $urandom_range(cur_ceil > cur_floor ?
                             cur_ceil - cur_floor : 300)) & 16'hffff;
        endcase
    endfunction

    task automatic request(input int col, input int row);
        send_word(1'b1, $urandom_range(65535), $urandom_range(65535), col, row);
    endtask

    task automatic set_up(input int w, input int h, input int lo, input int hi);
        cur_floor = lo; cur_ceil = hi;
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_FLOOR, lo);
        write_reg(REG_CEILING, hi);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(input int w, input int h, input int lo, input int hi,
                             input int mode, input int count, input bit hold);
        int ew, eh, size;
        case (mode)
            0:
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                gap_pct = 63;
                stall_pct = 0;
            end
            2:
            begin
                gap_pct = 0;
                stall_pct = 63;
            end
            default:
            begin
                gap_pct = 23;
                stall_pct = 23;
            end
        endcase
        set_up(w, h, lo, hi);
        ew = (w > MAX_DIM) ? MAX_DIM : w;
        eh = (h > MAX_DIM) ? MAX_DIM : h;
        size = ew * eh;
        for (int i = 0; i < size; i++)
            send_word(1'b0, i, pick_height(), $urandom_range(255), $urandom_range(255));
        for (int i = 0; i < count; i++)
        begin
            if (hold && i == count / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            case ($urandom_range(9))
                0: send_word(1'b0, $urandom_range(65535), $urandom_range(65535),
                             $urandom_range(255), $urandom_range(255));
                1, 2: send_word(1'b0, $urandom_range(size - 1), pick_height(),
                                $urandom_range(255), $urandom_range(255));
                3, 4: request($urandom_range(31), $urandom_range(31));
                5: request($urandom_range(100, 160), $urandom_range(100, 160));
                default: request($urandom_range(255), $urandom_range(255));
            endcase
        end
        drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        request(0, 0);
        request(255, 255);
        drain();
        set_up(1, 7, 0, 65535);
        request(128, 128);
        drain();

        set_up(2, 2, 0, 65535);
        send_word(1'b0, 0, 0, 0, 0);
        send_word(1'b0, 1, 65535, 255, 255);
        send_word(1'b0, 2, 32768, 0, 255);
        send_word(1'b0, 3, 1, 255, 0);
        request(0, 0);
        request(255, 255);
        request(255, 0);
        request(0, 255);
        request(16, 0);
        request(0, 15);
        request(1, 1);
        request(128, 128);
        request(200, 200);
        drain();

        run_phase(511, 2, 100, 60000, 0, 36, 1'b0);
        run_phase(3, 2, 1000, 1000, 1, 36, 1'b1);
        run_phase(9, 5, 65535, 0, 2, 36, 1'b0);
        run_phase(6, 6, 200, 40000, 3, 36, 1'b0);
        run_phase(3, 10, 0, 255, 1, 36, 1'b0);
        run_phase(10, 3, 0, 65535, 2, 36, 1'b0);
        run_phase(2, 12, 65534, 65535, 0, 36, 1'b0);

        if (errors == 0)
            $display("PASS heightmap_thumbnail_pixel_gen");
        else
            $display("FAIL heightmap_thumbnail_pixel_gen");
        $finish;
    end

endmodule
